/* hdl/rgb_color_classifier_top_defines.svh */
// ----------------------------------------------------------------------------
// RGB color classifier assertion macros
// Concurrent check wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_COLOR_CLASSIFIER_TOP_DEFINES_SVH
`define RGB_COLOR_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RCC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rcc check failed");
`define RCC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) else $error("rcc check failed");
`else
`define RCC_ASSERT(label, prop)
`define RCC_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* hdl/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// RGB color classifier package
// Widths, register indexes, color codes and thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

    localparam int WIDTH_W  = 17;
    localparam int MARGIN_W = 10;
    localparam int LEVEL_W  = 8;
    localparam int CODE_W   = 3;
    localparam int INDEX_W  = 4;
    localparam int NUM_W    = WIDTH_W + LEVEL_W;
    localparam int NUM_CH   = 3;
    localparam int DIV_STAGES = LEVEL_W;

    localparam logic [INDEX_W-1:0] REG_RED_LOW     = 4'd0;
    localparam logic [INDEX_W-1:0] REG_RED_HIGH    = 4'd1;
    localparam logic [INDEX_W-1:0] REG_GREEN_LOW   = 4'd2;
    localparam logic [INDEX_W-1:0] REG_GREEN_HIGH  = 4'd3;
    localparam logic [INDEX_W-1:0] REG_BLUE_LOW    = 4'd4;
    localparam logic [INDEX_W-1:0] REG_BLUE_HIGH   = 4'd5;
    localparam logic [INDEX_W-1:0] REG_EMPTY_LIMIT = 4'd6;
    localparam logic [INDEX_W-1:0] REG_MARGIN      = 4'd7;

    localparam logic [CODE_W-1:0] CODE_UNKNOWN   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_NO_OBJECT = 3'd1;
    localparam logic [CODE_W-1:0] CODE_BLACK     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_WHITE     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RED       = 3'd4;
    localparam logic [CODE_W-1:0] CODE_GREEN     = 3'd5;
    localparam logic [CODE_W-1:0] CODE_BLUE      = 3'd6;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 8'd255;
    localparam logic [LEVEL_W-1:0] BLACK_MAX_LIMIT = 8'd50;
    localparam logic [LEVEL_W-1:0] WHITE_MAX_LIMIT = 8'd140;
    localparam logic [LEVEL_W-1:0] WHITE_MIN_LIMIT = 8'd90;
    localparam logic [LEVEL_W-1:0] WHITE_SPREAD    = 8'd90;

    typedef struct packed {
        logic       any_zero;
        logic       no_obj;
        logic [2:0] beats;
    } flags_t;

endpackage

`default_nettype wire

/* hdl/rgb_color_classifier_top.sv */
// ----------------------------------------------------------------------------
// RGB color classifier
// Maps four pulse widths to three levels and a color code, pipelined.
// ----------------------------------------------------------------------------
// Input: pulse widths are taken with start while busy is low; busy stays
// low, so a reading can enter on every cycle.
// Config: cfg_valid/cfg_ready write cfg_data to register cfg_index;
// cfg_ready is always high, indexes above seven are dropped. Write only
// while no reading is in flight.
// Output: done is high for one cycle with the three levels and color_code.
// One result is produced per cycle. Each reading passes through twelve
// register stages: clamp, multiply, eight restoring-division stages
// (one quotient bit each), level and classify; the clamp stage loads
// at the accept edge itself.
// The receiver cannot stall; results are never held back.
// Reset clears all valid bits and loads the default calibration.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_color_classifier_top_defines.svh"

module rgb_color_classifier_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rcc_pkg::WIDTH_W-1:0]    red_width,
    input  wire logic [rcc_pkg::WIDTH_W-1:0]    green_width,
    input  wire logic [rcc_pkg::WIDTH_W-1:0]    blue_width,
    input  wire logic [rcc_pkg::WIDTH_W-1:0]    clear_width,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rcc_pkg::INDEX_W-1:0]    cfg_index,
    input  wire logic [rcc_pkg::WIDTH_W-1:0]    cfg_data,
    output logic                                done,
    output logic [rcc_pkg::LEVEL_W-1:0]         red_level,
    output logic [rcc_pkg::LEVEL_W-1:0]         green_level,
    output logic [rcc_pkg::LEVEL_W-1:0]         blue_level,
    output logic [rcc_pkg::CODE_W-1:0]          color_code
);

    localparam int W  = rcc_pkg::WIDTH_W;
    localparam int NW = rcc_pkg::NUM_W;
    localparam int LW = rcc_pkg::LEVEL_W;
    localparam int NC = rcc_pkg::NUM_CH;
    localparam int DS = rcc_pkg::DIV_STAGES;

    logic [W-1:0]                 lo_reg [NC];
    logic [W-1:0]                 hi_reg [NC];
    logic [W-1:0]                 limit_reg;
    logic [rcc_pkg::MARGIN_W-1:0] margin_reg;

    logic [W-1:0]  win   [NC];
    logic [W-1:0]  clamp_next [NC];
    logic [W:0]    sum_next [NC];

    logic                 a_vld_reg;
    logic [W-1:0]         a_n_reg [NC];
    logic [W-1:0]         a_d_reg [NC];
    logic [NC-1:0]        a_ok_reg;
    logic [W:0]           a_sum_reg [NC];
    logic [W-1:0]         a_w_reg [NC];
    logic                 a_zero_reg;
    logic                 a_noobj_reg;

    logic                 b_vld_reg;
    logic [NW-1:0]        b_num_reg [NC];
    logic [W-1:0]         b_d_reg [NC];
    logic [NC-1:0]        b_ok_reg;
    rcc_pkg::flags_t      b_flags_reg;

    logic                 dv_vld_reg [DS];
    logic [NW-1:0]        dv_rem_reg [DS][NC];
    logic [LW-1:0]        dv_q_reg [DS][NC];
    logic [W-1:0]         dv_d_reg [DS][NC];
    logic [NC-1:0]        dv_ok_reg [DS];
    rcc_pkg::flags_t      dv_flags_reg [DS];

    logic [NW-1:0]        dv_rem_next [DS][NC];
    logic [LW-1:0]        dv_q_next [DS][NC];

    logic                 c_vld_reg;
    logic [LW-1:0]        c_lvl_reg [NC];
    rcc_pkg::flags_t      c_flags_reg;

    logic [LW-1:0]        lvl_max;
    logic [LW-1:0]        lvl_min;
    logic [rcc_pkg::CODE_W-1:0] code_next;

    logic                 done_reg;
    logic [LW-1:0]        out_lvl_reg [NC];
    logic [rcc_pkg::CODE_W-1:0] code_reg;

    logic                 accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign win[0] = red_width;
    assign win[1] = green_width;
    assign win[2] = blue_width;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg[0]  <= W'(55);
            hi_reg[0]  <= W'(90);
            lo_reg[1]  <= W'(100);
            hi_reg[1]  <= W'(180);
            lo_reg[2]  <= W'(100);
            hi_reg[2]  <= W'(180);
            limit_reg  <= W'(120);
            margin_reg <= rcc_pkg::MARGIN_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcc_pkg::REG_RED_LOW:     lo_reg[0]  <= cfg_data;
                rcc_pkg::REG_RED_HIGH:    hi_reg[0]  <= cfg_data;
                rcc_pkg::REG_GREEN_LOW:   lo_reg[1]  <= cfg_data;
                rcc_pkg::REG_GREEN_HIGH:  hi_reg[1]  <= cfg_data;
                rcc_pkg::REG_BLUE_LOW:    lo_reg[2]  <= cfg_data;
                rcc_pkg::REG_BLUE_HIGH:   hi_reg[2]  <= cfg_data;
                rcc_pkg::REG_EMPTY_LIMIT: limit_reg  <= cfg_data;
                rcc_pkg::REG_MARGIN:      margin_reg <= cfg_data[rcc_pkg::MARGIN_W-1:0];
                default:                  ;
            endcase
        end
    end

    // clamp to window, form margin sums
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            if (win[c] < lo_reg[c])
                clamp_next[c] = lo_reg[c];
            else if (win[c] > hi_reg[c])
                clamp_next[c] = hi_reg[c];
            else
                clamp_next[c] = win[c];
            sum_next[c] = {1'b0, win[c]} + (W+1)'(margin_reg);
        end
    end

    // division stage: one quotient bit per stage, most significant first
    always_comb
    begin
        logic [NW:0]   trial;
        logic [NW-1:0] rem_in;
        logic [LW-1:0] q_in;
        logic [W-1:0]  d_in;
        for (int k = 0; k < DS; k++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                if (k == 0)
                begin
                    rem_in = b_num_reg[c];
                    q_in   = '0;
                    d_in   = b_d_reg[c];
                end
                else
                begin
                    rem_in = dv_rem_reg[k-1][c];
                    q_in   = dv_q_reg[k-1][c];
                    d_in   = dv_d_reg[k-1][c];
                end
                trial = {1'b0, rem_in} - ((NW+1)'(d_in) << (DS - 1 - k));
                if (!trial[NW])
                begin
                    dv_rem_next[k][c] = trial[NW-1:0];
                    dv_q_next[k][c]   = q_in | (LW'(1) << (DS - 1 - k));
                end
                else
                begin
                    dv_rem_next[k][c] = rem_in;
                    dv_q_next[k][c]   = q_in;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
            for (int k = 0; k < DS; k++)
                dv_vld_reg[k] <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            dv_vld_reg[0] <= b_vld_reg;
            for (int k = 1; k < DS; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            c_vld_reg <= dv_vld_reg[DS-1];
            done_reg  <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage A: clamp and offset
        for (int c = 0; c < NC; c++)
        begin
            a_n_reg[c]   <= clamp_next[c] - lo_reg[c];
            a_d_reg[c]   <= hi_reg[c] - lo_reg[c];
            a_ok_reg[c]  <= hi_reg[c] > lo_reg[c];
            a_sum_reg[c] <= sum_next[c];
            a_w_reg[c]   <= win[c];
        end
        a_zero_reg  <= (red_width == '0) || (green_width == '0) ||
                       (blue_width == '0) || (clear_width == '0);
        a_noobj_reg <= clear_width > limit_reg;

        // stage B: times 255, dominance compares
        for (int c = 0; c < NC; c++)
        begin
            b_num_reg[c] <= (NW'(a_n_reg[c]) << LW) - NW'(a_n_reg[c]);
            b_d_reg[c]   <= a_d_reg[c];
        end
        b_ok_reg             <= a_ok_reg;
        b_flags_reg.any_zero <= a_zero_reg;
        b_flags_reg.no_obj   <= a_noobj_reg;
        b_flags_reg.beats[0] <= (a_sum_reg[0] < (W+1)'(a_w_reg[1])) &&
                                (a_sum_reg[0] < (W+1)'(a_w_reg[2]));
        b_flags_reg.beats[1] <= (a_sum_reg[1] < (W+1)'(a_w_reg[0])) &&
                                (a_sum_reg[1] < (W+1)'(a_w_reg[2]));
        b_flags_reg.beats[2] <= (a_sum_reg[2] < (W+1)'(a_w_reg[0])) &&
                                (a_sum_reg[2] < (W+1)'(a_w_reg[1]));

        // division stages
        for (int k = 0; k < DS; k++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                dv_rem_reg[k][c] <= dv_rem_next[k][c];
                dv_q_reg[k][c]   <= dv_q_next[k][c];
                dv_d_reg[k][c]   <= (k == 0) ? b_d_reg[c] : dv_d_reg[k-1][c];
            end
            dv_ok_reg[k]    <= (k == 0) ? b_ok_reg : dv_ok_reg[k-1];
            dv_flags_reg[k] <= (k == 0) ? b_flags_reg : dv_flags_reg[k-1];
        end

        // stage C: levels
        for (int c = 0; c < NC; c++)
            c_lvl_reg[c] <= dv_ok_reg[DS-1][c] ?
                            (rcc_pkg::LEVEL_FULL - dv_q_reg[DS-1][c]) : '0;
        c_flags_reg <= dv_flags_reg[DS-1];

        // output stage
        for (int c = 0; c < NC; c++)
            out_lvl_reg[c] <= c_lvl_reg[c];
        code_reg <= code_next;
    end

    always_comb
    begin
        lvl_max = c_lvl_reg[0];
        lvl_min = c_lvl_reg[0];
        for (int c = 1; c < NC; c++)
        begin
            if (c_lvl_reg[c] > lvl_max)
                lvl_max = c_lvl_reg[c];
            if (c_lvl_reg[c] < lvl_min)
                lvl_min = c_lvl_reg[c];
        end
        if (c_flags_reg.any_zero)
            code_next = rcc_pkg::CODE_UNKNOWN;
        else if (c_flags_reg.no_obj)
            code_next = rcc_pkg::CODE_NO_OBJECT;
        else if (lvl_max < rcc_pkg::BLACK_MAX_LIMIT)
            code_next = rcc_pkg::CODE_BLACK;
        else if (lvl_max > rcc_pkg::WHITE_MAX_LIMIT && lvl_min > rcc_pkg::WHITE_MIN_LIMIT
                 && (lvl_max - lvl_min) < rcc_pkg::WHITE_SPREAD)
            code_next = rcc_pkg::CODE_WHITE;
        else if (c_flags_reg.beats[0])
            code_next = rcc_pkg::CODE_RED;
        else if (c_flags_reg.beats[1])
            code_next = rcc_pkg::CODE_GREEN;
        else if (c_flags_reg.beats[2])
            code_next = rcc_pkg::CODE_BLUE;
        else
            code_next = rcc_pkg::CODE_UNKNOWN;
    end

    assign done        = done_reg;
    assign red_level   = out_lvl_reg[0];
    assign green_level = out_lvl_reg[1];
    assign blue_level  = out_lvl_reg[2];
    assign color_code  = code_reg;

    `RCC_ASSERT(a_code_range, done |-> color_code <= rcc_pkg::CODE_BLUE)
    `RCC_ASSERT(a_black_dark, (done && color_code == rcc_pkg::CODE_BLACK) |-> (red_level < rcc_pkg::BLACK_MAX_LIMIT && green_level < rcc_pkg::BLACK_MAX_LIMIT && blue_level < rcc_pkg::BLACK_MAX_LIMIT))
    `RCC_ASSERT(a_white_bright, (done && color_code == rcc_pkg::CODE_WHITE) |-> (red_level > rcc_pkg::WHITE_MIN_LIMIT && green_level > rcc_pkg::WHITE_MIN_LIMIT && blue_level > rcc_pkg::WHITE_MIN_LIMIT))
    `RCC_ASSERT(a_div_rem, (dv_vld_reg[DS-1] && dv_ok_reg[DS-1][0]) |-> dv_rem_reg[DS-1][0] < NW'(dv_d_reg[DS-1][0]))
    `RCC_ASSERT_ALWAYS(a_busy_low, !busy)

endmodule

`default_nettype wire

/* dv/tb_rgb_color_classifier_top.sv */
// ----------------------------------------------------------------------------
// RGB color classifier testbench
// Drives readings through the start/busy port and checks every done transfer
// against an in-bench predictor of levels and color code, over several
// calibration settings and sender idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rgb_color_classifier_top;

    localparam int LATENCY   = 11;
    localparam int WDOG_MAX  = 2000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [rcc_pkg::LEVEL_W-1:0] red;
        logic [rcc_pkg::LEVEL_W-1:0] green;
        logic [rcc_pkg::LEVEL_W-1:0] blue;
        logic [rcc_pkg::CODE_W-1:0]  code;
    } reading_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [rcc_pkg::WIDTH_W-1:0]  red_width;
    logic [rcc_pkg::WIDTH_W-1:0]  green_width;
    logic [rcc_pkg::WIDTH_W-1:0]  blue_width;
    logic [rcc_pkg::WIDTH_W-1:0]  clear_width;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [rcc_pkg::INDEX_W-1:0]  cfg_index;
    logic [rcc_pkg::WIDTH_W-1:0]  cfg_data;
    logic                         done;
    logic [rcc_pkg::LEVEL_W-1:0]  red_level;
    logic [rcc_pkg::LEVEL_W-1:0]  green_level;
    logic [rcc_pkg::LEVEL_W-1:0]  blue_level;
    logic [rcc_pkg::CODE_W-1:0]   color_code;

    logic [rcc_pkg::WIDTH_W-1:0]  cal_lo [rcc_pkg::NUM_CH];
    logic [rcc_pkg::WIDTH_W-1:0]  cal_hi [rcc_pkg::NUM_CH];
    logic [rcc_pkg::WIDTH_W-1:0]  clear_limit;
    logic [rcc_pkg::MARGIN_W-1:0] margin;

    reading_t pending_readings[$];
    int       mismatches;
    int       idle_pct;
    int       wdog = 0;
    bit       timed_out;

    rgb_color_classifier_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .red_width   (red_width),
        .green_width (green_width),
        .blue_width  (blue_width),
        .clear_width (clear_width),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .color_code  (color_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [rcc_pkg::LEVEL_W-1:0] map_level(
            logic [rcc_pkg::WIDTH_W-1:0] w,
            logic [rcc_pkg::WIDTH_W-1:0] lo, logic [rcc_pkg::WIDTH_W-1:0] hi);
        logic [rcc_pkg::WIDTH_W-1:0] c;
        longint unsigned             q;
        if (hi <= lo)
            return '0;
        c = (w < lo) ? lo : ((w > hi) ? hi : w);
        q = (longint'(c - lo) * 255) / longint'(hi - lo);
        return 8'(255 - q);
    endfunction

    function automatic bit shorter(logic [rcc_pkg::WIDTH_W-1:0] a,
            logic [rcc_pkg::WIDTH_W-1:0] b, logic [rcc_pkg::WIDTH_W-1:0] c);
        longint unsigned s;
        s = longint'(a) + longint'(margin);
        return (s < b) && (s < c);
    endfunction

    function automatic reading_t classify(logic [rcc_pkg::WIDTH_W-1:0] r,
            logic [rcc_pkg::WIDTH_W-1:0] g, logic [rcc_pkg::WIDTH_W-1:0] b,
            logic [rcc_pkg::WIDTH_W-1:0] c);
        reading_t   res;
        logic [7:0] mx;
        logic [7:0] mn;
        res.red   = map_level(r, cal_lo[0], cal_hi[0]);
        res.green = map_level(g, cal_lo[1], cal_hi[1]);
        res.blue  = map_level(b, cal_lo[2], cal_hi[2]);
        mx = res.red;
        if (res.green > mx) mx = res.green;
        if (res.blue > mx) mx = res.blue;
        mn = res.red;
        if (res.green < mn) mn = res.green;
        if (res.blue < mn) mn = res.blue;
        if (r == 0 || g == 0 || b == 0 || c == 0)
            res.code = rcc_pkg::CODE_UNKNOWN;
        else if (c > clear_limit)
            res.code = rcc_pkg::CODE_NO_OBJECT;
        else if (mx < rcc_pkg::BLACK_MAX_LIMIT)
            res.code = rcc_pkg::CODE_BLACK;
        else if (mx > rcc_pkg::WHITE_MAX_LIMIT && mn > rcc_pkg::WHITE_MIN_LIMIT
                 && (mx - mn) < rcc_pkg::WHITE_SPREAD)
            res.code = rcc_pkg::CODE_WHITE;
        else if (shorter(r, g, b))
            res.code = rcc_pkg::CODE_RED;
        else if (shorter(g, r, b))
            res.code = rcc_pkg::CODE_GREEN;
        else if (shorter(b, r, g))
            res.code = rcc_pkg::CODE_BLUE;
        else
            res.code = rcc_pkg::CODE_UNKNOWN;
        return res;
    endfunction

    // start stays high after a transfer; a later idle wait or drain drops it
    task automatic send_reading(logic [rcc_pkg::WIDTH_W-1:0] r,
            logic [rcc_pkg::WIDTH_W-1:0] g, logic [rcc_pkg::WIDTH_W-1:0] b,
            logic [rcc_pkg::WIDTH_W-1:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        red_width   <= r;
        green_width <= g;
        blue_width  <= b;
        clear_width <= c;
        pending_readings.push_back(classify(r, g, b, c));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [rcc_pkg::INDEX_W-1:0] idx,
            logic [rcc_pkg::WIDTH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            rcc_pkg::REG_RED_LOW:     cal_lo[0] = val;
            rcc_pkg::REG_RED_HIGH:    cal_hi[0] = val;
            rcc_pkg::REG_GREEN_LOW:   cal_lo[1] = val;
            rcc_pkg::REG_GREEN_HIGH:  cal_hi[1] = val;
            rcc_pkg::REG_BLUE_LOW:    cal_lo[2] = val;
            rcc_pkg::REG_BLUE_HIGH:   cal_hi[2] = val;
            rcc_pkg::REG_EMPTY_LIMIT: clear_limit = val;
            rcc_pkg::REG_MARGIN:      margin = val[rcc_pkg::MARGIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_calibration(logic [rcc_pkg::WIDTH_W-1:0] rl,
            logic [rcc_pkg::WIDTH_W-1:0] rh, logic [rcc_pkg::WIDTH_W-1:0] gl,
            logic [rcc_pkg::WIDTH_W-1:0] gh, logic [rcc_pkg::WIDTH_W-1:0] bl,
            logic [rcc_pkg::WIDTH_W-1:0] bh, logic [rcc_pkg::WIDTH_W-1:0] lim,
            logic [rcc_pkg::WIDTH_W-1:0] m);
        drain();
        write_reg(rcc_pkg::REG_RED_LOW, rl);
        write_reg(rcc_pkg::REG_RED_HIGH, rh);
        write_reg(rcc_pkg::REG_GREEN_LOW, gl);
        write_reg(rcc_pkg::REG_GREEN_HIGH, gh);
        write_reg(rcc_pkg::REG_BLUE_LOW, bl);
        write_reg(rcc_pkg::REG_BLUE_HIGH, bh);
        write_reg(rcc_pkg::REG_EMPTY_LIMIT, lim);
        write_reg(rcc_pkg::REG_MARGIN, m);
    endtask

    function automatic logic [rcc_pkg::WIDTH_W-1:0] rand_width(int lo, int hi);
        case ($urandom_range(9))
            0:       return rcc_pkg::WIDTH_W'($urandom_range(131071));
            1:       return '0;
            default: return rcc_pkg::WIDTH_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic test_directed();
        send_reading(17'd1, 17'd1, 17'd1, 17'd1);
        send_reading(17'd0, 17'd120, 17'd120, 17'd60);
        send_reading(17'd60, 17'd0, 17'd120, 17'd60);
        send_reading(17'd60, 17'd120, 17'd0, 17'd60);
        send_reading(17'd60, 17'd120, 17'd120, 17'd0);
        send_reading(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        send_reading(17'd60, 17'd120, 17'd120, 17'd121);
        send_reading(17'd60, 17'd120, 17'd120, 17'd120);
        send_reading(17'd90, 17'd180, 17'd180, 17'd100);
        send_reading(17'd56, 17'd101, 17'd101, 17'd100);
        send_reading(17'd56, 17'd170, 17'd170, 17'd100);
        send_reading(17'd89, 17'd101, 17'd170, 17'd100);
        send_reading(17'd89, 17'd170, 17'd101, 17'd100);
        send_reading(17'd70, 17'd78, 17'd78, 17'd100);
        send_reading(17'd70, 17'd79, 17'd79, 17'd100);
        send_reading(17'd100000, 17'd100000, 17'd100000, 17'd100000);
        drain();
        write_reg(4'd8, 17'h1FFFF);
        write_reg(4'd15, 17'd5);
        send_reading(17'd60, 17'd120, 17'd120, 17'd60);
        set_calibration(17'd90, 17'd55, 17'd100, 17'd100, 17'd0, 17'h1FFFF,
                        17'h1FFFF, 17'h3FF);
        send_reading(17'd60, 17'd120, 17'd0, 17'd60);
        send_reading(17'd1, 17'd100, 17'h1FFFF, 17'h1FFFF);
        send_reading(17'd1, 17'd1100, 17'd1100, 17'd5);
    endtask

    task automatic random_phase(int n, int pct, int lo, int hi);
        idle_pct = pct;
        repeat (n)
            send_reading(rand_width(lo, hi), rand_width(lo, hi), rand_width(lo, hi),
                         rand_width(lo / 2, hi));
    endtask

    task automatic test_random();
        set_calibration(17'd55, 17'd90, 17'd100, 17'd180, 17'd100, 17'd180, 17'd120, 17'd8);
        random_phase(60, 0, 40, 200);
        random_phase(60, 70, 40, 200);
        set_calibration(17'd20, 17'd300, 17'd30, 17'd250, 17'd25, 17'd400, 17'd500, 17'd0);
        random_phase(60, 0, 10, 420);
        random_phase(50, 18, 10, 420);
        set_calibration(17'd0, 17'd100000, 17'd0, 17'd100000, 17'd0, 17'd100000,
                        17'd100000, 17'd1023);
        random_phase(50, 70, 1, 100000);
        set_calibration(rcc_pkg::WIDTH_W'($urandom_range(200)),
                        rcc_pkg::WIDTH_W'($urandom_range(400, 200)),
                        rcc_pkg::WIDTH_W'($urandom_range(200)),
                        rcc_pkg::WIDTH_W'($urandom_range(400, 200)),
                        rcc_pkg::WIDTH_W'($urandom_range(200)),
                        rcc_pkg::WIDTH_W'($urandom_range(400, 200)),
                        rcc_pkg::WIDTH_W'($urandom_range(400, 50)),
                        rcc_pkg::WIDTH_W'($urandom_range(40)));
        random_phase(80, 0, 1, 450);
        random_phase(70, 70, 1, 450);
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: unexpected result transfer %0d %0d %0d code %0d",
                             red_level, green_level, blue_level, color_code);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (want !== {red_level, green_level, blue_level, color_code})
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("ERROR: expected %0d %0d %0d code %0d, got %0d %0d %0d code %0d",
                                 want.red, want.green, want.blue, want.code,
                                 red_level, green_level, blue_level, color_code);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        red_width   = '0;
        green_width = '0;
        blue_width  = '0;
        clear_width = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        idle_pct    = 0;
        timed_out   = 1'b0;
        cal_lo      = '{17'd55, 17'd100, 17'd100};
        cal_hi      = '{17'd90, 17'd180, 17'd180};
        clear_limit = 17'd120;
        margin      = 10'd8;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            begin
                test_directed();
                test_random();
                drain();
            end
            begin
                wait (wdog >= WDOG_MAX);
                timed_out = 1'b1;
            end
        join_any
        disable fork;
        if (!timed_out && mismatches == 0 && pending_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* rgb_color_classifier_top.f */
+incdir+hdl
hdl/rcc_pkg.sv
hdl/rgb_color_classifier_top.sv
dv/tb_rgb_color_classifier_top.sv
